>>> hdl/ppf_pkg.sv
package ppf_pkg;

	// fixed geometry of one pattern word
	localparam int GROUPS_PER_WORD = 8;
	localparam int TABLE_ENTRIES   = 256;
	localparam int BYTE_W          = 8;

	// register and derived count widths
	localparam int SC_W  = 13;
	localparam int GRP_W = 11;
	localparam int WRD_W = 8;

	// register byte addresses (index in paddr[2])
	localparam logic REG_SAMPLE_COUNT = 1'b0;

	// item actions; code 3 is unused and dropped
	typedef enum logic [1:0] {
		ACT_SCAN   = 2'd0,
		ACT_UPDATE = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	// configuration view handed to the datapath
	typedef struct packed {
		logic [GRP_W-1:0] group_count;
		logic [WRD_W-1:0] word_count;
		logic             restart;
	} cfg_t;

endpackage

>>> hdl/ppf_bank.sv
module ppf_bank #(
	parameter int DEPTH  = 16384,
	parameter int ADDR_W = 14
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic              wdata,
	output logic              rdata
);

	logic mem_q [DEPTH];
	logic rdata_q;

	// single port presence bitmap, registered read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/ppf_cfg.sv
module ppf_cfg #(
	parameter int MAX_SAMPLES = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output ppf_pkg::cfg_t cfg
);
	import ppf_pkg::*;

	localparam int COUNT_RESET = (MAX_SAMPLES < 4096) ? MAX_SAMPLES : 4096;

	logic [SC_W-1:0]  sample_count_q;
	logic [SC_W-1:0]  wr_val;
	logic [SC_W-1:0]  wr_sat;
	logic             wr_en;
	logic [SC_W:0]    grp_sum;
	logic [GRP_W-1:0] groups;
	logic [GRP_W:0]   wrd_sum;

	// write strobe, register 0 only
	assign wr_en  = psel & penable & pwrite & (paddr[2] == REG_SAMPLE_COUNT);
	assign wr_val = pwdata[SC_W-1:0];

	// zero reads as one, large values saturate
	always_comb begin
		wr_sat = wr_val;
		if (wr_val == '0) begin
			wr_sat = SC_W'(1);
		end else if (32'(wr_val) > MAX_SAMPLES) begin
			wr_sat = SC_W'(MAX_SAMPLES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= SC_W'(COUNT_RESET);
		end else if (wr_en) begin
			sample_count_q <= wr_sat;
		end
	end

	// groups and words per pattern
	assign grp_sum = {1'b0, sample_count_q} + (SC_W+1)'(7);
	assign groups  = grp_sum[SC_W:3];
	assign wrd_sum = {1'b0, groups} + (GRP_W+1)'(7);

	assign cfg.group_count  = groups;
	assign cfg.word_count   = WRD_W'(wrd_sum[GRP_W:3]);
	assign cfg.restart      = wr_en;

	assign prdata = (paddr[2] == REG_SAMPLE_COUNT) ? 32'(sample_count_q) : 32'd0;

endmodule

>>> hdl/pattern_presence_filter.sv
// Result: once its ending word is taken, a result passes stage 1 and then the output register.
// Throughput: one pattern word per cycle unless the sweep or a stalled result lowers s_tready;
// eight bitmap banks are read or written in parallel. Clear: zeroes all MAX_WORDS*256 entries
// per bank (16384 by default) in a sweep that takes no input; its result does not wait for it.
// Reset: asynchronous; the same clearing sweep runs after reset before the first transfer,
// configuration writes are taken throughout.
module pattern_presence_filter #(
	parameter int MAX_SAMPLES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] pattern_word
	input  logic [1:0]  s_tuser,   // [1:0] action
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] is_new, [7:1] zero
	output logic [1:0]  m_tuser    // [1:0] done_kind
);
	import ppf_pkg::*;

	localparam int MAX_GROUPS = (MAX_SAMPLES + 7) / 8;
	localparam int MAX_WORDS  = (MAX_GROUPS + GROUPS_PER_WORD - 1) / GROUPS_PER_WORD;
	localparam int WP_W       = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int BANK_DEPTH = MAX_WORDS * TABLE_ENTRIES;
	localparam int ADDR_W     = $clog2(BANK_DEPTH);

	cfg_t cfg;

	logic                       accept;
	action_t                    act;
	logic                       act_ok;
	logic [WP_W-1:0]            wp_q;
	logic [WP_W-1:0]            wp_eff;
	logic                       last;
	logic [GROUPS_PER_WORD-1:0] mask;

	logic                       sweep_q;
	logic [ADDR_W-1:0]          sweep_cnt_q;

	logic [GROUPS_PER_WORD-1:0] bank_we;
	logic [GROUPS_PER_WORD-1:0] bank_rd;
	logic                       bank_re;

	logic                       valid_s1;
	action_t                    act_s1;
	logic                       last_s1;
	logic [GROUPS_PER_WORD-1:0] mask_s1;

	logic                       miss_q;
	logic                       miss;
	logic                       res_s1;
	logic                       adv_s1;
	logic                       out_free;

	logic                       out_valid_q;
	logic                       out_new_q;
	action_t                    out_kind_q;

	ppf_cfg #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	assign pready = 1'b1;

	// input decode
	assign act    = action_t'(s_tuser);
	assign act_ok = (act == ACT_SCAN) || (act == ACT_UPDATE) || (act == ACT_CLEAR);
	assign accept = s_tvalid & s_tready;

	// word position within the pattern
	assign wp_eff = (WRD_W'(wp_q) >= cfg.word_count) ? '0 : wp_q;
	assign last   = (WRD_W'(wp_eff) + WRD_W'(1)) >= cfg.word_count;

	always_comb begin
		for (int k = 0; k < GROUPS_PER_WORD; k++) begin
			mask[k] = 16'({wp_eff, 3'(k)}) < 16'(cfg.group_count);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
		end else if (cfg.restart) begin
			wp_q <= '0;
		end else if (accept) begin
			unique case (act)
				ACT_SCAN, ACT_UPDATE: wp_q <= last ? '0 : wp_eff + WP_W'(1);
				ACT_CLEAR:            wp_q <= '0;
				default:              wp_q <= wp_q;
			endcase
		end
	end

	// clearing sweep, after reset and on a clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= 1'b1;
			sweep_cnt_q <= '0;
		end else if (sweep_q) begin
			sweep_cnt_q <= sweep_cnt_q + ADDR_W'(1);
			if (sweep_cnt_q == ADDR_W'(BANK_DEPTH - 1)) begin
				sweep_q <= 1'b0;
			end
		end else if (accept && act == ACT_CLEAR) begin
			sweep_q     <= 1'b1;
			sweep_cnt_q <= '0;
		end
	end

	// bitmap banks, one per byte group of the word
	assign bank_re = accept & (act == ACT_SCAN);

	for (genvar k = 0; k < GROUPS_PER_WORD; k++) begin : g_bank
		logic [ADDR_W-1:0] addr;

		assign addr = sweep_q ? sweep_cnt_q
		                      : ADDR_W'({wp_eff, s_tdata[BYTE_W*k +: BYTE_W]});
		assign bank_we[k] = sweep_q | (accept & (act == ACT_UPDATE) & mask[k]);

		ppf_bank #(
			.DEPTH (BANK_DEPTH),
			.ADDR_W(ADDR_W)
		) u_bank (
			.clk  (clk),
			.we   (bank_we[k]),
			.re   (bank_re),
			.addr (addr),
			.wdata(~sweep_q),
			.rdata(bank_rd[k])
		);
	end

	// stage 1: lookup result
	assign miss     = (act_s1 == ACT_SCAN) & |(mask_s1 & ~bank_rd);
	assign res_s1   = (act_s1 == ACT_CLEAR) | last_s1;
	assign out_free = ~out_valid_q | m_tready;
	assign adv_s1   = ~res_s1 | out_free;
	assign s_tready = ~sweep_q & (~valid_s1 | adv_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (~valid_s1 | adv_s1) begin
			valid_s1 <= accept & act_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1  <= act;
			last_s1 <= last;
			mask_s1 <= mask;
		end
	end

	// miss accumulation over the words of a pattern
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_q <= 1'b0;
		end else if (cfg.restart) begin
			miss_q <= 1'b0;
		end else if (valid_s1 && adv_s1) begin
			if (res_s1) begin
				miss_q <= 1'b0;
			end else begin
				miss_q <= miss_q | miss;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 & res_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && res_s1) begin
			out_new_q  <= (act_s1 == ACT_SCAN) & (miss_q | miss);
			out_kind_q <= act_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_new_q};
	assign m_tuser  = out_kind_q;

endmodule
